FILE: rtl/core/tmrc_pkg.sv
`timescale 1ns / 1ps

package tmrc_pkg;

    // Address space and tile geometry limits
    localparam int ADDR_BITS       = 24;
    localparam int MAX_TILE_DIM    = 64;
    localparam int BYTES_PER_PIXEL = 3;

    // First address past the end of the byte space
    localparam logic [63:0] ADDR_LIMIT = 64'(1) << ADDR_BITS;

    // Job queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // APB address width: eight registers at word spacing
    localparam int PADDR_W = 5;

    // Register indexes
    typedef enum logic [2:0] {
        REG_TILE_WIDTH    = 3'd0,
        REG_TILE_HEIGHT   = 3'd1,
        REG_TILES_PER_ROW = 3'd2,
        REG_SRC_STRIDE    = 3'd3,
        REG_SRC_HEIGHT    = 3'd4,
        REG_DST_STRIDE    = 3'd5,
        REG_DST_HEIGHT    = 3'd6,
        REG_MAP_COLUMNS   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [6:0]  tile_width;
        logic [6:0]  tile_height;
        logic [8:0]  tiles_per_row;
        logic [13:0] src_stride;
        logic [12:0] src_height;
        logic [13:0] dst_stride;
        logic [12:0] dst_height;
        logic [12:0] map_columns;
    } t_cfg;

    typedef struct packed {
        logic [15:0] tile_id;
        logic [11:0] map_col;
        logic [11:0] map_row;
    } t_req;

    typedef struct packed {
        logic [23:0] src_addr;
        logic [23:0] dst_addr;
        logic [7:0]  row_bytes;
        logic        last_row;
        logic        fault;
    } t_res;

    // Classified tile handed from front to back
    typedef struct packed {
        logic        fault;
        logic [23:0] s_top;
        logic [23:0] d_top;
    } t_job;

endpackage

FILE: rtl/core/tmrc_queue.sv
`timescale 1ns / 1ps

module tmrc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tmrc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tmrc_pkg::t_job o_job
);
    import tmrc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    // Store an entry on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/tmrc_front.sv
`timescale 1ns / 1ps

module tmrc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmrc_pkg::t_cfg i_cfg,
    input  logic           i_start,
    input  tmrc_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_push,
    output tmrc_pkg::t_job o_job,
    input  logic           i_full
);
    import tmrc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL1,
        S_CHK,
        S_MUL2,
        S_OVF,
        S_PUSH
    } t_state;

    t_state      r_state;
    logic [11:0] r_col;
    logic [11:0] r_row;
    logic [15:0] r_quo;
    logic [8:0]  r_rem;
    logic [3:0]  r_cnt;
    logic [14:0] r_tx;
    logic [21:0] r_ty;
    logic [17:0] r_xpos;
    logic [17:0] r_ypos;
    logic [12:0] r_sdiff;
    logic [12:0] r_ddiff;
    logic [17:0] r_tx3;
    logic [20:0] r_x3;
    logic [28:0] r_stop;
    logic [28:0] r_dtop;
    logic        r_fault;

    logic        early_fault;
    logic [9:0]  n_rem_sh;
    logic [9:0]  n_rem_sub;
    logic        n_ge;
    logic        chk_fault;
    logic [29:0] s_end;
    logic [29:0] d_end;
    logic        ovf_fault;
    logic [8:0]  nbytes;

    // Reject bad geometry or a column past the map at accept
    assign early_fault = ({1'b0, i_req.map_col} >= i_cfg.map_columns) ||
                         (i_cfg.tile_width == '0) || (i_cfg.tile_height == '0) ||
                         (i_cfg.tile_width > 7'(MAX_TILE_DIM)) ||
                         (i_cfg.tile_height > 7'(MAX_TILE_DIM)) ||
                         (i_cfg.tiles_per_row == '0);

    // One restoring divide step per cycle
    assign n_rem_sh  = {r_rem, r_quo[15]};
    assign n_ge      = (n_rem_sh >= {1'b0, i_cfg.tiles_per_row});
    assign n_rem_sub = n_rem_sh - {1'b0, i_cfg.tiles_per_row};

    // Tile must lie inside the tileset and the destination bitmap
    assign chk_fault =
        ((23'(r_ty) + 23'(i_cfg.tile_height)) > 23'(i_cfg.src_height)) ||
        (((18'(r_tx) + 18'(i_cfg.tile_width)) * 18'(BYTES_PER_PIXEL))
            > 18'(i_cfg.src_stride)) ||
        ((19'(r_ypos) + 19'(i_cfg.tile_height)) > 19'(i_cfg.dst_height)) ||
        (((21'(r_xpos) + 21'(i_cfg.tile_width)) * 21'(BYTES_PER_PIXEL))
            > 21'(i_cfg.dst_stride));

    // Last byte of the top row must stay inside the address space
    assign nbytes    = 9'(i_cfg.tile_width * BYTES_PER_PIXEL);
    assign s_end     = 30'(r_stop) + 30'(nbytes);
    assign d_end     = 30'(r_dtop) + 30'(nbytes);
    assign ovf_fault = (64'(s_end) > ADDR_LIMIT) || (64'(d_end) > ADDR_LIMIT);

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_full;

    always_comb begin
        o_job.fault = r_fault;
        o_job.s_top = r_fault ? '0 : r_stop[23:0];
        o_job.d_top = r_fault ? '0 : r_dtop[23:0];
    end

    // Sequence one request through divide, placement, checks and queue push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_col   <= i_req.map_col;
                        r_row   <= i_req.map_row;
                        r_quo   <= i_req.tile_id;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_fault <= early_fault;
                        r_state <= early_fault ? S_PUSH : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_ge ? n_rem_sub[8:0] : n_rem_sh[8:0];
                    r_quo <= {r_quo[14:0], n_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_tx    <= 15'(r_rem) * 15'(i_cfg.tile_width);
                    r_ty    <= 22'(r_quo) * 22'(i_cfg.tile_height);
                    r_xpos  <= 18'(r_col) * 18'(i_cfg.tile_width);
                    r_ypos  <= 18'(r_row) * 18'(i_cfg.tile_height);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_sdiff <= 13'(i_cfg.src_height - 13'd1 - 13'(r_ty));
                    r_ddiff <= 13'(i_cfg.dst_height - 13'd1 - 13'(r_ypos));
                    r_tx3   <= 18'(r_tx) * 18'(BYTES_PER_PIXEL);
                    r_x3    <= 21'(r_xpos) * 21'(BYTES_PER_PIXEL);
                    r_fault <= chk_fault;
                    r_state <= chk_fault ? S_PUSH : S_MUL2;
                end
                S_MUL2: begin
                    r_stop  <= 29'(i_cfg.src_stride) * 29'(r_sdiff) + 29'(r_tx3);
                    r_dtop  <= 29'(i_cfg.dst_stride) * 29'(r_ddiff) + 29'(r_x3);
                    r_state <= S_OVF;
                end
                S_OVF: begin
                    r_fault <= ovf_fault;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/tmrc_back.sv
`timescale 1ns / 1ps

module tmrc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmrc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  tmrc_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_res_valid,
    output tmrc_pkg::t_res o_res
);
    import tmrc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_ROWS
    } t_state;

    t_state      r_state;
    logic [23:0] r_src;
    logic [23:0] r_dst;
    logic [5:0]  r_cnt;
    logic        r_valid;
    t_res        r_res;

    logic        is_last;
    logic [7:0]  row_bytes;

    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    assign is_last   = (r_cnt == 6'(i_cfg.tile_height - 7'd1));
    assign row_bytes = 8'(i_cfg.tile_width * BYTES_PER_PIXEL);

    // Take a job and issue one row command a cycle, top row first, or a lone fault result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (i_valid) begin
                        if (i_job.fault) begin
                            r_valid           <= 1'b1;
                            r_res.src_addr    <= '0;
                            r_res.dst_addr    <= '0;
                            r_res.row_bytes   <= '0;
                            r_res.last_row    <= 1'b1;
                            r_res.fault       <= 1'b1;
                        end else begin
                            r_src   <= i_job.s_top;
                            r_dst   <= i_job.d_top;
                            r_cnt   <= '0;
                            r_state <= S_ROWS;
                        end
                    end
                end
                S_ROWS: begin
                    r_valid         <= 1'b1;
                    r_res.src_addr  <= r_src;
                    r_res.dst_addr  <= r_dst;
                    r_res.row_bytes <= row_bytes;
                    r_res.last_row  <= is_last;
                    r_res.fault     <= 1'b0;
                    r_src           <= r_src - 24'(i_cfg.src_stride);
                    r_dst           <= r_dst - 24'(i_cfg.dst_stride);
                    r_cnt           <= r_cnt + 6'd1;
                    if (is_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/tile_map_row_copy_generator_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                     Payload
// request   start, busy (take: start&!busy) i_req  (tile_id, map_col, map_row)
// result    o_res_valid, valid per command o_res  (src/dst addr, bytes, last, fault)
// config    APB psel/penable/pwrite        paddr, pwdata, prdata; pready tied high
//
// The front runs a restoring divide of the tile id by tiles_per_row, then placement,
// range and overflow checks and a push; an entry rejected at accept goes straight
// to the push. The back pops a job, then issues tile_height row commands, one per
// cycle. A full two-entry job queue holds the front (busy stays high), so once a
// tile's rows outlast the front's work per request, the back sets the rate. Synchronous
// active-low reset empties both parts and the queue, restores register defaults; results never stall.

module tile_map_row_copy_generator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  tmrc_pkg::t_req                 i_req,
    output logic                           o_res_valid,
    output tmrc_pkg::t_res                 o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tmrc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_job     push_job;
    t_job     head_job;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_width    <= 7'd16;
            r_cfg.tile_height   <= 7'd16;
            r_cfg.tiles_per_row <= 9'd16;
            r_cfg.src_stride    <= 14'd768;
            r_cfg.src_height    <= 13'd256;
            r_cfg.dst_stride    <= 14'd768;
            r_cfg.dst_height    <= 13'd256;
            r_cfg.map_columns   <= 13'd16;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TILE_WIDTH:    r_cfg.tile_width    <= pwdata[6:0];
                REG_TILE_HEIGHT:   r_cfg.tile_height   <= pwdata[6:0];
                REG_TILES_PER_ROW: r_cfg.tiles_per_row <= pwdata[8:0];
                REG_SRC_STRIDE:    r_cfg.src_stride    <= pwdata[13:0];
                REG_SRC_HEIGHT:    r_cfg.src_height    <= pwdata[12:0];
                REG_DST_STRIDE:    r_cfg.dst_stride    <= pwdata[13:0];
                REG_DST_HEIGHT:    r_cfg.dst_height    <= pwdata[12:0];
                REG_MAP_COLUMNS:   r_cfg.map_columns   <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            REG_TILE_WIDTH:    prdata = 32'(r_cfg.tile_width);
            REG_TILE_HEIGHT:   prdata = 32'(r_cfg.tile_height);
            REG_TILES_PER_ROW: prdata = 32'(r_cfg.tiles_per_row);
            REG_SRC_STRIDE:    prdata = 32'(r_cfg.src_stride);
            REG_SRC_HEIGHT:    prdata = 32'(r_cfg.src_height);
            REG_DST_STRIDE:    prdata = 32'(r_cfg.dst_stride);
            REG_DST_HEIGHT:    prdata = 32'(r_cfg.dst_height);
            REG_MAP_COLUMNS:   prdata = 32'(r_cfg.map_columns);
            default:           prdata = '0;
        endcase
    end

    tmrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_push  (q_push),
        .o_job   (push_job),
        .i_full  (q_full)
    );

    tmrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    tmrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

FILE: rtl/core/tmrc_checker.sv
`timescale 1ns / 1ps

module tmrc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input tmrc_pkg::t_req               i_req,
    input logic                         o_res_valid,
    input tmrc_pkg::t_res               o_res,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [tmrc_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                  pwdata,
    input logic [31:0]                  prdata,
    input logic                         pready
);
    import tmrc_pkg::*;

    // A taken request keeps the front busy in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low right after a request was taken");

    // Reset leaves no result strobe behind
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe right after reset");

    // A faulted result is a lone, empty final command
    a_fault_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.fault |-> o_res.last_row && (o_res.src_addr == '0) &&
            (o_res.dst_addr == '0) && (o_res.row_bytes == '0))
        else $error("faulted result carries a copy");

    // Copy commands never have zero length
    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.fault |-> (o_res.row_bytes != '0))
        else $error("copy command with zero length");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low during a transfer");

endmodule

bind tile_map_row_copy_generator_core tmrc_checker u_tmrc_checker (.*);

FILE: sim/tmrc_row_checker.sv
`timescale 1ns / 1ps

module tmrc_row_checker
    import tmrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  t_req                i_req,
    input  logic                i_res_valid,
    input  t_res                i_res,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_errors,
    output int                  o_pending
);

    localparam t_cfg GEOMETRY_AT_RESET = '{
        tile_width:    7'd16,
        tile_height:   7'd16,
        tiles_per_row: 9'd16,
        src_stride:    14'd768,
        src_height:    13'd256,
        dst_stride:    14'd768,
        dst_height:    13'd256,
        map_columns:   13'd16
    };
    localparam int PRINT_CAP = 30;

    t_cfg geometry = GEOMETRY_AT_RESET;
    t_res row_cmds_due[$];
    int   mismatches = 0;

    // Print the first few mismatches, count all of them
    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] row command mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Work out every copy command one map entry produces under the current geometry
    function automatic void plan_row_copies(input t_req r);
        logic [63:0] id, col, row, tw, th, tpr;
        logic [63:0] ss, sh, ds, dh, nbytes, tx, ty, xpos, ypos, s_top, d_top, i;
        logic        reject;
        t_res        cmd;
        id  = 64'(r.tile_id);
        col = 64'(r.map_col);
        row = 64'(r.map_row);
        tw  = 64'(geometry.tile_width);
        th  = 64'(geometry.tile_height);
        tpr = 64'(geometry.tiles_per_row);
        ss  = 64'(geometry.src_stride);
        sh  = 64'(geometry.src_height);
        ds  = 64'(geometry.dst_stride);
        dh  = 64'(geometry.dst_height);
        nbytes = tw * BYTES_PER_PIXEL;

        // Reject columns past the map and unusable tile geometry before dividing
        reject = (col >= 64'(geometry.map_columns)) || (tw == 0) || (th == 0) ||
                 (tw > MAX_TILE_DIM) || (th > MAX_TILE_DIM) || (tpr == 0);

        // Place the tile in the tileset and in the map, check it fits both
        if (!reject) begin
            tx   = (id % tpr) * tw;
            ty   = (id / tpr) * th;
            xpos = col * tw;
            ypos = row * th;
            reject = (ty + th > sh) || ((tx + tw) * BYTES_PER_PIXEL > ss) ||
                     (ypos + th > dh) || ((xpos + tw) * BYTES_PER_PIXEL > ds);
        end

        // Bottom-up bitmaps: the top image row sits at the highest address
        if (!reject) begin
            s_top  = ss * (sh - 1 - ty) + tx * BYTES_PER_PIXEL;
            d_top  = ds * (dh - 1 - ypos) + xpos * BYTES_PER_PIXEL;
            reject = (s_top + nbytes > ADDR_LIMIT) || (d_top + nbytes > ADDR_LIMIT);
        end

        if (reject) begin
            cmd          = '0;
            cmd.last_row = 1'b1;
            cmd.fault    = 1'b1;
            row_cmds_due.push_back(cmd);
        end else begin
            for (i = 0; i < th; i++) begin
                cmd.src_addr  = 24'(s_top - ss * i);
                cmd.dst_addr  = 24'(d_top - ds * i);
                cmd.row_bytes = 8'(nbytes);
                cmd.last_row  = (i + 1 == th);
                cmd.fault     = 1'b0;
                row_cmds_due.push_back(cmd);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            geometry = GEOMETRY_AT_RESET;
            row_cmds_due.delete();
        end else begin
            // Compare each row command with the oldest one still due
            if (i_res_valid) begin
                if (row_cmds_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected command %p", i_res));
                end else begin
                    want = row_cmds_due.pop_front();
                    if (i_res.src_addr !== want.src_addr)
                        report_mismatch($sformatf("src_addr %h, want %h",
                                                  i_res.src_addr, want.src_addr));
                    if (i_res.dst_addr !== want.dst_addr)
                        report_mismatch($sformatf("dst_addr %h, want %h",
                                                  i_res.dst_addr, want.dst_addr));
                    if (i_res.row_bytes !== want.row_bytes)
                        report_mismatch($sformatf("row_bytes %0d, want %0d",
                                                  i_res.row_bytes, want.row_bytes));
                    if (i_res.last_row !== want.last_row)
                        report_mismatch($sformatf("last_row %b, want %b",
                                                  i_res.last_row, want.last_row));
                    if (i_res.fault !== want.fault)
                        report_mismatch($sformatf("fault %b, want %b",
                                                  i_res.fault, want.fault));
                end
            end

            // Predict the commands of an accepted request
            if (i_start && !i_busy)
                plan_row_copies(i_req);

            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_TILE_WIDTH:    geometry.tile_width    = i_pwdata[6:0];
                    REG_TILE_HEIGHT:   geometry.tile_height   = i_pwdata[6:0];
                    REG_TILES_PER_ROW: geometry.tiles_per_row = i_pwdata[8:0];
                    REG_SRC_STRIDE:    geometry.src_stride    = i_pwdata[13:0];
                    REG_SRC_HEIGHT:    geometry.src_height    = i_pwdata[12:0];
                    REG_DST_STRIDE:    geometry.dst_stride    = i_pwdata[13:0];
                    REG_DST_HEIGHT:    geometry.dst_height    = i_pwdata[12:0];
                    REG_MAP_COLUMNS:   geometry.map_columns   = i_pwdata[12:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= mismatches;
        o_pending <= row_cmds_due.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tmrc_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1500;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    t_req               i_req   = '0;
    logic               o_res_valid;
    t_res               o_res;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 errors;
    int                 pending;
    int unsigned        quiet_cycles = 0;
    t_cfg               cur_cfg;

    always #6 i_clk = ~i_clk;

    tile_map_row_copy_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tmrc_row_checker u_row_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_res_valid (o_res_valid),
        .i_res       (o_res),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tile_map_row_copy_generator_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Setup then access phase; hold until pready
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_geometry(input t_cfg c);
        write_reg(REG_TILE_WIDTH,    32'(c.tile_width));
        write_reg(REG_TILE_HEIGHT,   32'(c.tile_height));
        write_reg(REG_TILES_PER_ROW, 32'(c.tiles_per_row));
        write_reg(REG_SRC_STRIDE,    32'(c.src_stride));
        write_reg(REG_SRC_HEIGHT,    32'(c.src_height));
        write_reg(REG_DST_STRIDE,    32'(c.dst_stride));
        write_reg(REG_DST_HEIGHT,    32'(c.dst_height));
        write_reg(REG_MAP_COLUMNS,   32'(c.map_columns));
        cur_cfg = c;
    endtask

    // Idle for gap cycles, then hold the request until it is taken
    task automatic send_tile(input t_req r, input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_entry(input int unsigned id, input int unsigned col,
                              input int unsigned row);
        t_req r;
        r.tile_id = 16'(id);
        r.map_col = 12'(col);
        r.map_row = 12'(row);
        send_tile(r, $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
    endtask

    // Drop start, wait out every due command and the front pipeline
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly small tiles with strides and heights that keep addresses in range
    function automatic t_cfg draw_geometry();
        t_cfg        c;
        int unsigned tw, th, fit, ss, ds;
        tw  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        th  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        fit = 12288 / (tw * 3);
        ss  = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12288)
                                          : tw * 3 * $urandom_range(1, fit);
        ds  = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12288)
                                          : tw * 3 * $urandom_range(1, fit);
        c.tile_width    = 7'(tw);
        c.tile_height   = 7'(th);
        c.tiles_per_row = 9'($urandom_range(0, 1) ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 256));
        c.src_stride    = 14'(ss);
        c.dst_stride    = 14'(ds);
        c.src_height    = 13'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                              : $urandom_range(th, min_u(4096, 16777216 / ss)));
        c.dst_height    = 13'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                              : $urandom_range(th, min_u(4096, 16777216 / ds)));
        c.map_columns   = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                          : $urandom_range(1, 64));
        return c;
    endfunction

    // Mostly entries that fit, some pushed just past one bound, some pure noise
    function automatic t_req draw_request(input t_cfg c);
        t_req        r;
        int unsigned tw, th, tpr, scols, srows, dcols, drows, kind, trow, tcol;
        tw    = c.tile_width;
        th    = c.tile_height;
        tpr   = c.tiles_per_row;
        r.tile_id = 16'($urandom);
        r.map_col = 12'($urandom);
        r.map_row = 12'($urandom);
        if (tw == 0 || th == 0 || tpr == 0)
            return r;
        scols = min_u(tpr, c.src_stride / (tw * 3));
        srows = c.src_height / th;
        dcols = min_u(min_u(c.map_columns, c.dst_stride / (tw * 3)), 4096);
        drows = min_u(c.dst_height / th, 4096);
        kind  = $urandom_range(0, 19);
        if (kind < 17 && scols > 0 && srows > 0 && dcols > 0 && drows > 0) begin
            trow = $urandom_range(0, srows - 1);
            tcol = $urandom_range(0, scols - 1);
            if (trow * tpr + tcol > 65535)
                trow = 0;
            r.tile_id = 16'(trow * tpr + tcol);
            r.map_col = 12'($urandom_range(0, dcols - 1));
            r.map_row = 12'($urandom_range(0, drows - 1));
            case (kind)
                14: r.map_col = 12'(dcols);
                15: r.map_row = 12'(drows);
                16: r.tile_id = 16'(srows * tpr + tcol);
                default: ;
            endcase
        end
        return r;
    endfunction

    initial begin
        t_cfg        g;
        int unsigned sent, n;
        bit          burst;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: corners of tileset and map, tile, column and row range faults
        send_entry(0, 0, 0);
        send_entry(255, 15, 15);
        send_entry(15, 15, 0);
        send_entry(240, 0, 15);
        send_entry(256, 0, 0);
        send_entry(3, 16, 0);
        send_entry(3, 0, 16);
        send_entry(65535, 4095, 4095);
        drain();

        // Unusable tile geometry
        write_reg(REG_TILE_WIDTH, 0);
        send_entry(1, 1, 1);
        drain();
        write_reg(REG_TILE_WIDTH, 127);
        send_entry(1, 1, 1);
        drain();
        write_reg(REG_TILE_WIDTH, 16);
        write_reg(REG_TILE_HEIGHT, 0);
        send_entry(1, 1, 1);
        drain();
        write_reg(REG_TILE_HEIGHT, 65);
        send_entry(1, 1, 1);
        drain();
        write_reg(REG_TILE_HEIGHT, 16);
        write_reg(REG_TILES_PER_ROW, 0);
        send_entry(1, 1, 1);
        send_entry(0, 0, 0);
        drain();

        // Largest geometry: one full tile that fits, one that overflows the address space, one past the tileset
        g = '{tile_width: 7'd64, tile_height: 7'd64, tiles_per_row: 9'd256,
              src_stride: 14'd12288, src_height: 13'd4096, dst_stride: 14'd12288,
              dst_height: 13'd4096, map_columns: 13'd4096};
        apply_geometry(g);
        send_entry(16191, 63, 63);
        send_entry(0, 0, 0);
        send_entry(65535, 63, 63);
        drain();

        // Smallest geometry: a single one-pixel tile
        g = '{tile_width: 7'd1, tile_height: 7'd1, tiles_per_row: 9'd1,
              src_stride: 14'd3, src_height: 13'd1, dst_stride: 14'd3,
              dst_height: 13'd1, map_columns: 13'd1};
        apply_geometry(g);
        send_entry(0, 0, 0);
        send_entry(1, 0, 0);
        drain();

        // Random geometries, each with a burst of entries
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            apply_geometry(draw_geometry());
            n = $urandom_range(10, 40);
            repeat (n) begin
                send_tile(draw_request(cur_cfg), burst ? 0 : $urandom_range(0, 18));
                sent++;
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("tile_map_row_copy_generator_core test passed");
        end else begin
            $display("tile_map_row_copy_generator_core test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tmrc_pkg.sv
rtl/core/tmrc_queue.sv
rtl/core/tmrc_front.sv
rtl/core/tmrc_back.sv
rtl/core/tile_map_row_copy_generator_core.sv
rtl/core/tmrc_checker.sv
sim/tmrc_row_checker.sv
sim/tb_top.sv
